[hw/rtl/caf_pkg.sv]
package caf_pkg;

    // Default operand width
    localparam int DATA_WIDTH_DEF = 16;

    // Condition codes
    localparam logic [1:0] COND_EQ     = 2'd0;
    localparam logic [1:0] COND_NE     = 2'd1;
    localparam logic [1:0] COND_GT     = 2'd2;
    localparam logic [1:0] COND_ALWAYS = 2'd3;

    // Operation codes
    localparam logic [3:0] FN_ADD  = 4'd0;
    localparam logic [3:0] FN_SUB  = 4'd1;
    localparam logic [3:0] FN_MUL  = 4'd2;
    localparam logic [3:0] FN_DIV  = 4'd3;
    localparam logic [3:0] FN_CMP  = 4'd4;
    localparam logic [3:0] FN_AND  = 4'd5;
    localparam logic [3:0] FN_OR   = 4'd6;
    localparam logic [3:0] FN_NOT  = 4'd7;
    localparam logic [3:0] FN_TEST = 4'd8;
    localparam logic [3:0] FN_MOV  = 4'd13;
    localparam logic [3:0] FN_SHL  = 4'd14;
    localparam logic [3:0] FN_SHR  = 4'd15;

    // Control between the sequencer and the multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } md_ctrl_t;

endpackage

[hw/rtl/caf_muldiv.sv]
module caf_muldiv
    import caf_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  md_ctrl_t              ctrl,
    input  logic [DATA_WIDTH-1:0] op_a,
    input  logic [DATA_WIDTH-1:0] op_b,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] result
);

    localparam int W     = DATA_WIDTH;
    localparam int CNT_W = $clog2(W + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic             div_reg;
    logic             neg_reg;
    logic             dz_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     rem_reg;   // accumulator for multiply, remainder for divide
    logic [W-1:0]     quo_reg;   // multiplier for multiply, dividend/quotient for divide
    logic [W-1:0]     dvs_reg;   // multiplicand for multiply, divisor for divide

    logic [W:0]       add_a;
    logic [W+1:0]     add_b;
    logic [W+1:0]     add_sum;
    logic [W-1:0]     abs_a;
    logic [W-1:0]     abs_b;

    // Magnitudes for signed division
    assign abs_a = op_a[W-1] ? (~op_a + W'(1)) : op_a;
    assign abs_b = op_b[W-1] ? (~op_b + W'(1)) : op_b;

    // Shared adder: accumulate for multiply, trial subtract for divide
    always_comb
    begin
        if (div_reg)
        begin
            add_a = {rem_reg, quo_reg[W-1]};
            add_b = ~{2'b00, dvs_reg};
        end
        else
        begin
            add_a = {1'b0, rem_reg};
            add_b = quo_reg[0] ? {2'b00, dvs_reg} : '0;
        end
        add_sum = {1'b0, add_a} + add_b + {{(W+1){1'b0}}, div_reg};
    end

    // Step the unit one bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            div_reg <= ctrl.is_div;
            rem_reg <= '0;
            neg_reg <= op_a[W-1] ^ op_b[W-1];
            dz_reg  <= (op_b == '0);
            if (ctrl.is_div)
            begin
                quo_reg <= abs_a;
                dvs_reg <= abs_b;
            end
            else
            begin
                quo_reg <= op_b;
                dvs_reg <= op_a;
            end
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                // Keep the difference unless the trial subtract borrowed
                if (add_sum[W+1])
                begin
                    rem_reg <= add_a[W-1:0];
                    quo_reg <= {quo_reg[W-2:0], 1'b0};
                end
                else
                begin
                    rem_reg <= add_sum[W-1:0];
                    quo_reg <= {quo_reg[W-2:0], 1'b1};
                end
            end
            else
            begin
                rem_reg <= add_sum[W-1:0];
                quo_reg <= {1'b0, quo_reg[W-1:1]};
                dvs_reg <= {dvs_reg[W-2:0], 1'b0};
            end
        end
    end

    // Fix sign of quotient; divide by zero yields zero
    always_comb
    begin
        if (!div_reg)
            result = rem_reg;
        else if (dz_reg)
            result = '0;
        else if (neg_reg)
            result = ~quo_reg + W'(1);
        else
            result = quo_reg;
    end

    assign done = done_reg;

endmodule

[hw/rtl/cond_alu_with_flags.sv]
// Conditional execute unit with Z/N/C/O flags, one item at a time.
// Multiply and divide go through the bit-serial shift-add / restoring-divide unit;
// other operations and failed conditions skip it and go from the execute state
// to the done state. tready returns as the result is presented, so the next item
// is taken only once the last result has been registered.
// Reset (rst_n, asynchronous, active low) clears all flags and drops tvalid.
module cond_alu_with_flags
    import caf_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // dst_value, src_value (from bit 0), zero padded to bytes
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    // cond_code, func (from bit 0)
    input  logic [5:0]                             s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // result_value, zero padded to bytes
    output logic [((DATA_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
    // write_back, executed, zero_flag, negative_flag, carry_flag,
    // overflow_flag (from bit 0)
    output logic [5:0]                             m_axis_tuser
);

    localparam int W     = DATA_WIDTH;
    localparam int SH_W  = $clog2(W);
    localparam int OUT_W = ((W + 7) / 8) * 8;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_MD   = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]   state_reg, state_next;
    logic [1:0]   cc_reg;
    logic [3:0]   fn_reg;
    logic [W-1:0] a_reg;
    logic [W-1:0] b_reg;
    logic [W-1:0] md_res_reg;
    logic         z_reg, n_reg, c_reg, o_reg;
    logic         z_next, n_next, c_next, o_next;
    logic         m_valid_reg;
    logic [W-1:0] m_res_reg;
    logic         m_wb_reg, m_exec_reg;

    logic         go;
    logic         is_md;
    logic         out_free;
    logic         finish;
    logic [W-1:0] r;
    logic         wb;
    logic [W-1:0] sum, diff;
    logic         big_shift;
    md_ctrl_t     md_ctrl;
    logic         md_done;
    logic [W-1:0] md_result;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign finish        = (state_reg == ST_DONE) && out_free;
    assign is_md         = (fn_reg == FN_MUL) || (fn_reg == FN_DIV);

    // Evaluate the condition against the current flags
    always_comb
    begin
        unique case (cc_reg)
            COND_EQ: go = z_reg;
            COND_NE: go = !z_reg;
            COND_GT: go = !n_reg;
            default: go = 1'b1;
        endcase
    end

    assign md_ctrl.start  = (state_reg == ST_EXEC) && go && is_md;
    assign md_ctrl.is_div = (fn_reg == FN_DIV);

    caf_muldiv #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (md_ctrl),
        .op_a   (a_reg),
        .op_b   (b_reg),
        .done   (md_done),
        .result (md_result)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (s_axis_tvalid)
                    state_next = ST_EXEC;
            ST_EXEC:
                state_next = (go && is_md) ? ST_MD : ST_DONE;
            ST_MD:
                if (md_done)
                    state_next = ST_DONE;
            default:
                if (out_free)
                    state_next = ST_IDLE;
        endcase
    end

    // Result and flag logic
    assign sum       = a_reg + b_reg;
    assign diff      = a_reg - b_reg;
    assign big_shift = (b_reg >= W'(W));

    always_comb
    begin
        r      = '0;
        wb     = 1'b0;
        z_next = z_reg;
        n_next = n_reg;
        c_next = c_reg;
        o_next = o_reg;
        if (go)
        begin
            unique case (fn_reg)
                FN_ADD:
                begin
                    r      = sum;
                    wb     = 1'b1;
                    o_next = (a_reg[W-1] ^ r[W-1]) & (b_reg[W-1] ^ r[W-1]);
                    c_next = o_next;
                end
                FN_SUB, FN_CMP:
                begin
                    r      = diff;
                    wb     = (fn_reg == FN_SUB);
                    o_next = (a_reg[W-1] ^ b_reg[W-1]) & (a_reg[W-1] ^ r[W-1]);
                    c_next = o_next;
                end
                FN_MUL, FN_DIV:
                begin
                    r  = md_res_reg;
                    wb = 1'b1;
                end
                FN_AND:
                begin
                    r  = a_reg & b_reg;
                    wb = 1'b1;
                end
                FN_OR:
                begin
                    r  = a_reg | b_reg;
                    wb = 1'b1;
                end
                FN_NOT:
                begin
                    r  = ~b_reg;
                    wb = 1'b1;
                end
                FN_TEST:
                    r = a_reg & b_reg;
                FN_MOV:
                begin
                    r  = b_reg;
                    wb = 1'b1;
                end
                FN_SHL:
                begin
                    r      = big_shift ? '0 : (a_reg << b_reg[SH_W-1:0]);
                    wb     = 1'b1;
                    c_next = a_reg[W-1];
                end
                FN_SHR:
                begin
                    r      = big_shift ? {W{a_reg[W-1]}}
                                       : W'($signed(a_reg) >>> b_reg[SH_W-1:0]);
                    wb     = 1'b1;
                    c_next = a_reg[0];
                end
                default:
                begin
                    r  = '0;
                    wb = 1'b0;
                end
            endcase
            // Stack ops leave Z and N alone
            if ((fn_reg <= FN_TEST) || (fn_reg >= FN_MOV))
            begin
                z_next = (r == '0);
                n_next = r[W-1];
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            z_reg       <= 1'b0;
            n_reg       <= 1'b0;
            c_reg       <= 1'b0;
            o_reg       <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                z_reg       <= z_next;
                n_reg       <= n_next;
                c_reg       <= c_next;
                o_reg       <= o_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Capture item, multiply/divide result and output payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cc_reg <= s_axis_tuser[1:0];
            fn_reg <= s_axis_tuser[5:2];
            a_reg  <= s_axis_tdata[W-1:0];
            b_reg  <= s_axis_tdata[2*W-1:W];
        end
        if (md_done)
            md_res_reg <= md_result;
        if (finish)
        begin
            m_res_reg  <= r;
            m_wb_reg   <= wb;
            m_exec_reg <= go;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_W'(m_res_reg);
    assign m_axis_tuser  = {o_reg, c_reg, n_reg, z_reg, m_exec_reg, m_wb_reg};

endmodule

[sim/cond_alu_with_flags_chk.sv]
`timescale 1ns / 100ps

module cond_alu_with_flags_chk
    import caf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // dst_value, src_value (from bit 0)
    input  logic [31:0] s_axis_tdata,
    // cond_code, func (from bit 0)
    input  logic [5:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_value
    input  logic [15:0] m_axis_tdata,
    // write_back, executed, zero_flag, negative_flag, carry_flag,
    // overflow_flag (from bit 0)
    input  logic [5:0]  m_axis_tuser,
    output int          mismatches,
    output int          outstanding
);

    localparam int W = DATA_WIDTH_DEF;

    // Low six bits line up with m_axis_tuser
    typedef struct packed {
        logic [W-1:0] result_value;
        logic         overflow_flag;
        logic         carry_flag;
        logic         negative_flag;
        logic         zero_flag;
        logic         executed;
        logic         write_back;
    } alu_outcome_t;

    localparam string FLAG_NAMES [6] = '{"write_back", "executed", "zero_flag",
                                         "negative_flag", "carry_flag", "overflow_flag"};

    logic         z_flag;
    logic         n_flag;
    logic         c_flag;
    logic         o_flag;
    alu_outcome_t alu_outcome_q [$];

    // Work out one item's outcome and advance the shadow flags
    function automatic alu_outcome_t execute_alu(input logic [1:0] cond,
                                                 input logic [3:0] func,
                                                 input logic [W-1:0] a,
                                                 input logic [W-1:0] b);
        logic                go;
        logic                wb;
        logic                sets_zn;
        logic                ovf;
        logic [W-1:0]        r;
        logic [2*W-1:0]      product;
        logic signed [31:0]  quotient;
        alu_outcome_t        res;

        case (cond)
            COND_EQ: go = z_flag;
            COND_NE: go = !z_flag;
            COND_GT: go = !n_flag;
            default: go = 1'b1;
        endcase
        r       = '0;
        wb      = 1'b0;
        sets_zn = 1'b1;
        if (go)
        begin
            case (func)
                FN_ADD, FN_SUB, FN_CMP:
                begin
                    if (func == FN_ADD)
                    begin
                        r   = a + b;
                        ovf = (a[W-1] ^ r[W-1]) & (b[W-1] ^ r[W-1]);
                    end
                    else
                    begin
                        r   = a - b;
                        ovf = (a[W-1] ^ b[W-1]) & (a[W-1] ^ r[W-1]);
                    end
                    o_flag = ovf;
                    c_flag = ovf;
                    wb     = (func != FN_CMP);
                end
                FN_MUL:
                begin
                    product = $signed(a) * $signed(b);
                    r       = product[W-1:0];
                    wb      = 1'b1;
                end
                FN_DIV:
                begin
                    // zero divisor gives zero; most negative over -1 wraps
                    if (b == '0)
                        r = '0;
                    else
                    begin
                        quotient = $signed(a) / $signed(b);
                        r        = quotient[W-1:0];
                    end
                    wb = 1'b1;
                end
                FN_AND:  begin r = a & b; wb = 1'b1; end
                FN_OR:   begin r = a | b; wb = 1'b1; end
                FN_NOT:  begin r = ~b;    wb = 1'b1; end
                FN_TEST: r = a & b;
                FN_MOV:  begin r = b;     wb = 1'b1; end
                FN_SHL:
                begin
                    // count is unsigned, so negative counts saturate as well
                    r      = (b >= W) ? '0 : (a << b);
                    c_flag = a[W-1];
                    wb     = 1'b1;
                end
                FN_SHR:
                begin
                    // keep the shift signed so the sign bit is copied in
                    if (b >= W)
                        r = {W{a[W-1]}};
                    else
                        r = $signed(a) >>> b;
                    c_flag = a[0];
                    wb     = 1'b1;
                end
                // stack operations: executed, but nothing else happens
                default: sets_zn = 1'b0;
            endcase
            if (sets_zn)
            begin
                z_flag = (r == '0);
                n_flag = r[W-1];
            end
        end
        res.result_value  = r;
        res.write_back    = wb;
        res.executed      = go;
        res.zero_flag     = z_flag;
        res.negative_flag = n_flag;
        res.carry_flag    = c_flag;
        res.overflow_flag = o_flag;
        return res;
    endfunction

    // Compare each result with the oldest outcome, then record new items
    always @(posedge clk or negedge rst_n)
    begin
        alu_outcome_t want;
        if (!rst_n)
        begin
            z_flag     = 1'b0;
            n_flag     = 1'b0;
            c_flag     = 1'b0;
            o_flag     = 1'b0;
            mismatches = 0;
            alu_outcome_q.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (alu_outcome_q.size() == 0)
                begin
                    $error("result with no item outstanding: tdata %h tuser %b",
                           m_axis_tdata, m_axis_tuser);
                    mismatches++;
                end
                else
                begin
                    want = alu_outcome_q.pop_front();
                    if (m_axis_tdata !== want.result_value)
                    begin
                        $error("result_value: expected %h, got %h",
                               want.result_value, m_axis_tdata);
                        mismatches++;
                    end
                    for (int i = 0; i < 6; i++)
                    begin
                        if (m_axis_tuser[i] !== want[i])
                        begin
                            $error("%s: expected %b, got %b",
                                   FLAG_NAMES[i], want[i], m_axis_tuser[i]);
                            mismatches++;
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                alu_outcome_q.insert(alu_outcome_q.size(),
                                     execute_alu(s_axis_tuser[1:0], s_axis_tuser[5:2],
                                                 s_axis_tdata[W-1:0],
                                                 s_axis_tdata[2*W-1:W]));
        end
        outstanding = alu_outcome_q.size();
    end

endmodule

[sim/cond_alu_with_flags_tb.sv]
`timescale 1ns / 100ps

module cond_alu_with_flags_tb;
    import caf_pkg::*;

    localparam int         W            = DATA_WIDTH_DEF;
    localparam int         RANDOM_ITEMS = 1300;
    localparam int         CALM_TAIL    = 150;
    localparam logic [3:0] FN_STACK_LO  = 4'd9;
    localparam logic [3:0] FN_STACK_HI  = 4'd12;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic [5:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [5:0]  m_axis_tuser;
    int          mismatches;
    int          outstanding;
    bit          calm          = 1'b0;

    cond_alu_with_flags u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    cond_alu_with_flags_chk u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // Result side: stall in random bursts, never while calm
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (calm)
                m_axis_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Biased towards the corners of the signed range
    function automatic logic [W-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'h0001;
            default: return W'($urandom);
        endcase
    endfunction

    // Present one item at a falling edge, hold until taken, then maybe idle
    task automatic send_item(input logic [1:0] cond, input logic [3:0] func,
                             input logic [W-1:0] dst, input logic [W-1:0] src);
        int gap;
        s_axis_tuser  <= {func, cond};
        s_axis_tdata  <= {src, dst};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            s_axis_tuser  <= 6'($urandom);
            repeat (gap) @(negedge clk);
        end
    endtask

    // Hold off the sender until every result is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [3:0]   fn;
        logic [W-1:0] a;
        logic [W-1:0] b;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Conditions against known flags, overflow corners
        send_item(COND_EQ,     FN_ADD,  16'h0001, 16'h0001);
        send_item(COND_ALWAYS, FN_ADD,  16'h7FFF, 16'h0001);
        send_item(COND_GT,     FN_ADD,  16'h0001, 16'h0001);
        send_item(COND_ALWAYS, FN_ADD,  16'h8000, 16'h8000);
        send_item(COND_EQ,     FN_MOV,  16'h0000, 16'h8000);
        send_item(COND_NE,     FN_SUB,  16'h8000, 16'h0001);
        send_item(COND_GT,     FN_CMP,  16'h0005, 16'h0005);
        // Multiply and divide, including zero divisor and wrap
        send_item(COND_EQ,     FN_MUL,  16'h7FFF, 16'h7FFF);
        send_item(COND_ALWAYS, FN_MUL,  16'h8000, 16'hFFFF);
        send_item(COND_ALWAYS, FN_DIV,  16'h8000, 16'hFFFF);
        send_item(COND_ALWAYS, FN_DIV,  16'h0064, 16'h0000);
        send_item(COND_ALWAYS, FN_DIV,  16'hFFF9, 16'h0002);
        // Logic operations
        send_item(COND_ALWAYS, FN_AND,  16'hFFFF, 16'h00FF);
        send_item(COND_ALWAYS, FN_OR,   16'h8000, 16'h0001);
        send_item(COND_ALWAYS, FN_NOT,  16'h0000, 16'hFFFF);
        send_item(COND_ALWAYS, FN_TEST, 16'hF0F0, 16'h0F0F);
        // Stack operations are not performed
        send_item(COND_ALWAYS, FN_STACK_LO, 16'h1234, 16'h5678);
        send_item(COND_EQ,     FN_STACK_HI, 16'hFFFF, 16'hFFFF);
        // Shifts: carry out, saturating and negative counts
        send_item(COND_ALWAYS, FN_SHL,  16'h8001, 16'h0001);
        send_item(COND_ALWAYS, FN_SHL,  16'h7FFF, 16'h0010);
        send_item(COND_ALWAYS, FN_SHL,  16'h0001, 16'hFFFF);
        send_item(COND_ALWAYS, FN_SHR,  16'h8001, 16'h0001);
        send_item(COND_ALWAYS, FN_SHR,  16'h8000, 16'h0010);
        send_item(COND_ALWAYS, FN_SHR,  16'h7FFE, 16'h0014);
        send_item(COND_ALWAYS, FN_SHR,  16'h8000, 16'h000F);
        drain_results();

        // Random items with calm stretches and a quiet tail
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i % 300 >= 250) || (i >= RANDOM_ITEMS - CALM_TAIL);
            if (i == RANDOM_ITEMS / 2)
                drain_results();
            fn = 4'($urandom_range(0, 15));
            a  = pick_operand();
            if ((fn == FN_SHL || fn == FN_SHR) && $urandom_range(0, 3) != 0)
                b = W'($urandom_range(0, 17));
            else
                b = pick_operand();
            send_item(2'($urandom_range(0, 3)), fn, a, b);
        end

        // Let the last results out, then settle
        drain_results();
        repeat (40) @(negedge clk);

        if (outstanding != 0)
            $error("%0d results never arrived", outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
